// ----- hdl/tw_pkg.sv -----
`default_nettype none
// ---------------------------------------------------------------------------
// tw_pkg: shared types and constants of the travelling wave displacer
// Controller states, datapath operations and the command and status
// structures that join the controller to the datapath.
// ---------------------------------------------------------------------------
package tw_pkg;

  // Register indexes on the configuration port.
  localparam logic [2:0] CFG_ENABLE      = 3'd0;
  localparam logic [2:0] CFG_AMOUNT      = 3'd1;
  localparam logic [2:0] CFG_REACH       = 3'd2;
  localparam logic [2:0] CFG_SPEED       = 3'd3;
  localparam logic [2:0] CFG_WAVE_LENGTH = 3'd4;
  localparam logic [2:0] CFG_DIRECTION   = 3'd5;

  // Arithmetic constants.
  localparam logic [32:0] INV_TWO_PI_K = 33'd683565276;
  localparam logic [32:0] SIN_A        = 33'd1686629713;
  localparam logic [32:0] SIN_B        = 33'd688904866;
  localparam logic [32:0] SIN_C        = 33'd76016977;
  localparam logic [15:0] MIN_WAVE     = 16'd41;
  localparam logic [15:0] DEG_FULL     = 16'd23040;
  localparam logic [15:0] DEG_HALF     = 16'd11520;

  // A full circle is 23040 = 512 * 45 steps, so the heading in turns is
  // dir * floor(2^23 / 45) plus floor((23 * dir + 22) / 45), and that last
  // quotient comes from a multiplication by ceil(2^26 / 45).
  localparam logic [17:0] ANG_K = 18'd186413;
  localparam logic [20:0] ANG_M = 21'd1491309;

  // Divider geometry: one quotient bit per step.
  localparam int          DIV_NUM_W = 60;
  localparam logic [5:0]  DIV_STEPS = 6'd60;

  typedef enum logic [4:0] {
    ST_IDLE, ST_DISPATCH, ST_TICK_MUL, ST_TICK_LO, ST_TICK_HI, ST_TICK_ADD,
    ST_PASS, ST_ANG_MUL, ST_ANG_FIX, ST_DIV, ST_SIN_X, ST_SIN_X2, ST_SIN_U,
    ST_SIN_V, ST_SIN_S, ST_PROJ_X, ST_PROJ_Z, ST_OFF_LOAD, ST_RA, ST_DISP_LO,
    ST_DISP_HI, ST_RES_DISP, ST_EMIT
  } state_t;

  typedef enum logic [4:0] {
    OP_NONE, OP_CAPTURE, OP_TICK_MUL, OP_TICK_LO, OP_TICK_HI, OP_TICK_ADD,
    OP_RES_PASS, OP_ANG_MUL, OP_ANG_FIX, OP_DIV_STEP, OP_SIN_X, OP_SIN_X2,
    OP_SIN_U, OP_SIN_V, OP_SIN_S, OP_PROJ_X, OP_PROJ_Z, OP_OFF_LOAD, OP_RA,
    OP_DISP_LO, OP_DISP_HI, OP_RES_DISP, OP_EMIT
  } op_t;

  typedef enum logic [1:0] {
    SEL_COS, SEL_SIN, SEL_WAVE
  } sin_sel_t;

  typedef struct packed {
    op_t      op;
    sin_sel_t sel;
  } cmd_t;

  typedef struct packed {
    logic div_done;
    logic out_free;
    logic is_point;
    logic enable;
  } status_t;

endpackage
`default_nettype wire

// ----- hdl/tw_ctrl.sv -----
`default_nettype none
// ---------------------------------------------------------------------------
// tw_ctrl: sequencer of the travelling wave displacer
// Steps the datapath through tick, pass and wave operations.
// ---------------------------------------------------------------------------
module tw_ctrl (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_valid,
  output logic                in_ready,
  input  wire tw_pkg::status_t status,
  output tw_pkg::cmd_t        cmd
);
  import tw_pkg::*;

  state_t   state_r, state_nxt;
  sin_sel_t sel_r, sel_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      sel_r   <= SEL_COS;
    end else begin
      state_r <= state_nxt;
      sel_r   <= sel_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    sel_nxt   = sel_r;
    cmd.op    = OP_NONE;
    cmd.sel   = sel_r;
    in_ready  = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.op    = OP_CAPTURE;
          state_nxt = ST_DISPATCH;
        end
      end
      ST_DISPATCH: begin
        if (!status.is_point) state_nxt = ST_TICK_MUL;
        else if (status.enable) state_nxt = ST_ANG_MUL;
        else state_nxt = ST_PASS;
      end
      ST_TICK_MUL: begin cmd.op = OP_TICK_MUL; state_nxt = ST_TICK_LO; end
      ST_TICK_LO:  begin cmd.op = OP_TICK_LO;  state_nxt = ST_TICK_HI; end
      ST_TICK_HI:  begin cmd.op = OP_TICK_HI;  state_nxt = ST_TICK_ADD; end
      ST_TICK_ADD: begin cmd.op = OP_TICK_ADD; state_nxt = ST_IDLE; end
      ST_PASS:     begin cmd.op = OP_RES_PASS; state_nxt = ST_EMIT; end
      ST_ANG_MUL: begin
        cmd.op    = OP_ANG_MUL;
        sel_nxt   = SEL_COS;
        state_nxt = ST_ANG_FIX;
      end
      ST_ANG_FIX: begin cmd.op = OP_ANG_FIX; state_nxt = ST_SIN_X; end
      ST_DIV: begin
        if (status.div_done) state_nxt = ST_SIN_X;
        else cmd.op = OP_DIV_STEP;
      end
      ST_SIN_X:  begin cmd.op = OP_SIN_X;  state_nxt = ST_SIN_X2; end
      ST_SIN_X2: begin cmd.op = OP_SIN_X2; state_nxt = ST_SIN_U; end
      ST_SIN_U:  begin cmd.op = OP_SIN_U;  state_nxt = ST_SIN_V; end
      ST_SIN_V:  begin cmd.op = OP_SIN_V;  state_nxt = ST_SIN_S; end
      ST_SIN_S: begin
        cmd.op = OP_SIN_S;
        case (sel_r)
          SEL_COS: begin sel_nxt = SEL_SIN; state_nxt = ST_SIN_X; end
          SEL_SIN: state_nxt = ST_PROJ_X;
          default: state_nxt = ST_RA;
        endcase
      end
      ST_PROJ_X: begin cmd.op = OP_PROJ_X; state_nxt = ST_PROJ_Z; end
      ST_PROJ_Z: begin cmd.op = OP_PROJ_Z; state_nxt = ST_OFF_LOAD; end
      ST_OFF_LOAD: begin
        cmd.op    = OP_OFF_LOAD;
        sel_nxt   = SEL_WAVE;
        state_nxt = ST_DIV;
      end
      ST_RA:       begin cmd.op = OP_RA;       state_nxt = ST_DISP_LO; end
      ST_DISP_LO:  begin cmd.op = OP_DISP_LO;  state_nxt = ST_DISP_HI; end
      ST_DISP_HI:  begin cmd.op = OP_DISP_HI;  state_nxt = ST_RES_DISP; end
      ST_RES_DISP: begin cmd.op = OP_RES_DISP; state_nxt = ST_EMIT; end
      ST_EMIT: begin
        if (status.out_free) begin
          cmd.op    = OP_EMIT;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

endmodule
`default_nettype wire

// ----- hdl/tw_datapath.sv -----
`default_nettype none
// ---------------------------------------------------------------------------
// tw_datapath: arithmetic of the travelling wave displacer
// Configuration registers, phase, one shared multiplier, a bit-serial
// divider, the sine polynomial registers and the output register.
// ---------------------------------------------------------------------------
module tw_datapath (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire tw_pkg::cmd_t       cmd,
  output tw_pkg::status_t         status,
  input  wire logic               in_opcode,
  input  wire logic [19:0]        in_delta_time,
  input  wire logic signed [23:0] in_point_x,
  input  wire logic signed [23:0] in_point_y,
  input  wire logic signed [23:0] in_point_z,
  input  wire logic               cfg_valid,
  input  wire logic [2:0]         cfg_index,
  input  wire logic [16:0]        cfg_data,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic signed [23:0]      out_x,
  output logic signed [23:0]      out_y,
  output logic signed [23:0]      out_z
);
  import tw_pkg::*;

  logic        enable_r;
  logic [16:0] amount_r;
  logic [15:0] reach_r, speed_r, wave_r;
  logic [14:0] dir_r;
  logic [31:0] phase_r;

  logic              op_r;
  logic [19:0]       dt_r;
  logic signed [23:0] px_r, py_r, pz_r;

  logic [35:0]        prod_r;
  logic signed [67:0] acc_r;
  logic [32:0]        ra_r;

  logic [DIV_NUM_W-1:0] num_r;
  logic [15:0]          den_r, rem_r;
  logic [31:0]          quot_r;
  logic [5:0]           cnt_r;
  logic                 pneg_r;

  logic [30:0]        x_r, x2_r, u_r, v_r, smag_r;
  logic               sneg_r;
  logic signed [31:0] cs_r, sn_r;

  logic signed [23:0] res_y_r;
  logic               out_valid_r;
  logic signed [23:0] out_x_r, out_y_r, out_z_r;

  // Heading correction term 23 * dir + 22, built from shifts.
  logic [19:0] ang_t;
  assign ang_t = {1'b0, dir_r, 4'b0} + {3'b0, dir_r, 2'b0} + {4'b0, dir_r, 1'b0}
               + {5'b0, dir_r} + 20'd22;

  // Shared multiplier.
  logic signed [32:0] mul_a, mul_b;
  logic signed [65:0] mul_p;
  logic signed [67:0] mul_ext;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd.op)
      OP_TICK_MUL: begin mul_a = {13'b0, dt_r}; mul_b = {17'b0, speed_r}; end
      OP_TICK_LO:  begin mul_a = {15'b0, prod_r[17:0]}; mul_b = INV_TWO_PI_K; end
      OP_TICK_HI:  begin mul_a = {15'b0, prod_r[35:18]}; mul_b = INV_TWO_PI_K; end
      OP_ANG_MUL:  begin mul_a = {18'b0, dir_r}; mul_b = {15'b0, ANG_K}; end
      OP_ANG_FIX:  begin mul_a = {13'b0, ang_t}; mul_b = {12'b0, ANG_M}; end
      OP_SIN_X2:   begin mul_a = {2'b0, x_r}; mul_b = {2'b0, x_r}; end
      OP_SIN_U:    begin mul_a = SIN_C; mul_b = {2'b0, x2_r}; end
      OP_SIN_V:    begin mul_a = {2'b0, u_r}; mul_b = {2'b0, x2_r}; end
      OP_SIN_S:    begin mul_a = {2'b0, x_r}; mul_b = {2'b0, v_r}; end
      OP_PROJ_X:   begin mul_a = {{9{px_r[23]}}, px_r}; mul_b = {cs_r[31], cs_r}; end
      OP_PROJ_Z:   begin mul_a = {{9{pz_r[23]}}, pz_r}; mul_b = {sn_r[31], sn_r}; end
      OP_RA:       begin mul_a = {17'b0, reach_r}; mul_b = {16'b0, amount_r}; end
      OP_DISP_LO:  begin mul_a = {2'b0, smag_r}; mul_b = {16'b0, ra_r[16:0]}; end
      OP_DISP_HI:  begin mul_a = {2'b0, smag_r}; mul_b = {17'b0, ra_r[32:17]}; end
      default: begin mul_a = '0; mul_b = '0; end
    endcase
  end

  assign mul_p   = mul_a * mul_b;
  assign mul_ext = {{2{mul_p[65]}}, mul_p};

  // Sine argument and quadrant folding.
  logic [31:0] sin_arg;
  always_comb begin
    case (cmd.sel)
      SEL_COS: sin_arg = quot_r + 32'h4000_0000;
      SEL_SIN: sin_arg = quot_r;
      default: sin_arg = phase_r + (pneg_r ? (32'd0 - quot_r) : quot_r);
    endcase
  end

  logic [30:0] fold_x;
  assign fold_x = sin_arg[30] ? (31'h4000_0000 - {1'b0, sin_arg[29:0]})
                              : {1'b0, sin_arg[29:0]};

  logic [31:0] s_signed;
  assign s_signed = sneg_r ? (32'd0 - {1'b0, mul_p[60:30]}) : {1'b0, mul_p[60:30]};

  // Divider step and loads.
  logic [16:0] trial;
  logic        qbit;
  assign trial = {rem_r, num_r[DIV_NUM_W-1]};
  assign qbit  = (trial >= {1'b0, den_r});

  logic [15:0]          wmax;
  logic [67:0]          acc_mag;
  logic [DIV_NUM_W-1:0] n_val;
  assign wmax    = (wave_r < MIN_WAVE) ? MIN_WAVE : wave_r;
  assign acc_mag = acc_r[67] ? (68'd0 - acc_r) : acc_r;
  assign n_val   = {acc_mag[DIV_NUM_W-3:0], 2'b00};

  // Rounded displacement and saturation.
  logic [67:0]        rnd;
  logic [17:0]        dmag;
  logic signed [25:0] ny;
  logic signed [23:0] ny_sat;
  assign rnd  = acc_r + (68'd1 <<< 45);
  assign dmag = rnd[63:46];
  assign ny   = sneg_r ? ({{2{py_r[23]}}, py_r} - $signed({8'b0, dmag}))
                       : ({{2{py_r[23]}}, py_r} + $signed({8'b0, dmag}));
  always_comb begin
    if (ny > 26'sd8388607) ny_sat = 24'sh7FFFFF;
    else if (ny < -26'sd8388608) ny_sat = 24'sh800000;
    else ny_sat = ny[23:0];
  end

  logic [67:0] tick_sum;
  assign tick_sum = acc_r + (68'd1 <<< 27);

  // Control and state registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enable_r    <= 1'b0;
      amount_r    <= 17'd0;
      reach_r     <= 16'd4096;
      speed_r     <= 16'd4096;
      wave_r      <= 16'd4096;
      dir_r       <= 15'd0;
      phase_r     <= 32'd0;
      out_valid_r <= 1'b0;
      cnt_r       <= 6'd0;
    end else begin
      if (cfg_valid) begin
        unique case (cfg_index)
          CFG_ENABLE:      enable_r <= cfg_data[0];
          CFG_AMOUNT:      amount_r <= cfg_data;
          CFG_REACH:       reach_r  <= cfg_data[15:0];
          CFG_SPEED:       speed_r  <= cfg_data[15:0];
          CFG_WAVE_LENGTH: wave_r   <= cfg_data[15:0];
          CFG_DIRECTION:   dir_r    <= cfg_data[14:0];
          default: ;
        endcase
      end
      if (cmd.op == OP_TICK_ADD) phase_r <= phase_r + tick_sum[59:28];
      if (cmd.op == OP_EMIT) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
      if (cmd.op == OP_OFF_LOAD) cnt_r <= 6'd0;
      else if (cmd.op == OP_DIV_STEP) cnt_r <= cnt_r + 6'd1;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_CAPTURE: begin
        op_r <= in_opcode;
        dt_r <= in_delta_time;
        px_r <= in_point_x;
        py_r <= in_point_y;
        pz_r <= in_point_z;
      end
      OP_TICK_MUL: prod_r <= mul_p[35:0];
      OP_TICK_LO:  acc_r  <= mul_ext;
      OP_TICK_HI:  acc_r  <= acc_r + (mul_ext <<< 18);
      OP_RES_PASS: res_y_r <= py_r;
      OP_ANG_MUL:  quot_r <= mul_p[31:0];
      OP_ANG_FIX:  quot_r <= quot_r + {17'b0, mul_p[40:26]};
      OP_OFF_LOAD: begin
        pneg_r <= acc_r[67];
        num_r  <= acc_r[67] ? (n_val + {44'b0, wmax} - 60'd1) : n_val;
        den_r  <= wmax;
        rem_r  <= 16'd0;
        quot_r <= 32'd0;
      end
      OP_DIV_STEP: begin
        num_r  <= {num_r[DIV_NUM_W-2:0], 1'b0};
        rem_r  <= qbit ? (trial[15:0] - den_r) : trial[15:0];
        quot_r <= {quot_r[30:0], qbit};
      end
      OP_SIN_X: begin
        x_r    <= fold_x;
        sneg_r <= sin_arg[31];
      end
      OP_SIN_X2: x2_r <= mul_p[60:30];
      OP_SIN_U:  u_r  <= SIN_B[30:0] - mul_p[60:30];
      OP_SIN_V:  v_r  <= SIN_A[30:0] - mul_p[60:30];
      OP_SIN_S: begin
        case (cmd.sel)
          SEL_COS: cs_r <= s_signed;
          SEL_SIN: sn_r <= s_signed;
          default: smag_r <= mul_p[60:30];
        endcase
      end
      OP_PROJ_X:   acc_r <= mul_ext;
      OP_PROJ_Z:   acc_r <= acc_r + mul_ext;
      OP_RA:       ra_r  <= mul_p[32:0];
      OP_DISP_LO:  acc_r <= mul_ext;
      OP_DISP_HI:  acc_r <= acc_r + (mul_ext <<< 17);
      OP_RES_DISP: res_y_r <= ny_sat;
      OP_EMIT: begin
        out_x_r <= px_r;
        out_y_r <= res_y_r;
        out_z_r <= pz_r;
      end
      default: ;
    endcase
  end

  assign status.div_done = (cnt_r == DIV_STEPS);
  assign status.out_free = !out_valid_r || out_ready;
  assign status.is_point = op_r;
  assign status.enable   = enable_r;

  assign out_valid = out_valid_r;
  assign out_x     = out_x_r;
  assign out_y     = out_y_r;
  assign out_z     = out_z_r;

endmodule
`default_nettype wire

// ----- hdl/travelling_wave_displace.sv -----
// Sequence: a tick beat updates the phase through the multiply, low, high and add steps; a
// point result comes from the pass step when the wave is disabled and the wave steps when enabled.
// Throughput: one beat at a time, the next taken only once the last is done (later while a
// result waits downstream); an enabled point is dominated by the 60-step bit-serial
// offset divider, plus three sine evaluations on the shared multiplier.
// Reset (rst_n low, synchronous): control and configuration registers return to their
// defaults, phase clears to zero and any pending result is dropped.
`default_nettype none
// ---------------------------------------------------------------------------
// travelling_wave_displace: sine-wave displacement of 3-D points
// Tick beats advance the wave phase; point beats have y displaced by the
// travelling wave and saturated when enabled (else passed), with x and z passed through.
// ---------------------------------------------------------------------------
module travelling_wave_displace (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic               in_opcode,
  input  wire logic [19:0]        in_delta_time,
  input  wire logic signed [23:0] in_point_x,
  input  wire logic signed [23:0] in_point_y,
  input  wire logic signed [23:0] in_point_z,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic signed [23:0]      out_x,
  output logic signed [23:0]      out_y,
  output logic signed [23:0]      out_z,
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic [2:0]         cfg_index,
  input  wire logic [16:0]        cfg_data
);
  import tw_pkg::*;

  cmd_t    cmd;
  status_t status;

  // Configuration writes are always taken; indexes past the register list
  // are simply ignored by the decoder in the datapath.
  assign cfg_ready = 1'b1;

  // The controller accepts a beat only from its idle state. The result of
  // the previous point sits in the output register, so a new beat can be
  // taken while that result still waits downstream.
  tw_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  // The datapath performs one operation per cycle as commanded: phase
  // update, the heading by reciprocal multiplication, the offset division,
  // the sine polynomial, the projection onto the wave direction and the
  // rounded, saturated displacement.
  tw_datapath u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .status        (status),
    .in_opcode     (in_opcode),
    .in_delta_time (in_delta_time),
    .in_point_x    (in_point_x),
    .in_point_y    (in_point_y),
    .in_point_z    (in_point_z),
    .cfg_valid     (cfg_valid),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_x         (out_x),
    .out_y         (out_y),
    .out_z         (out_z)
  );

`ifndef SYNTHESIS
  // Once a beat is taken the controller leaves idle, so the next cycle
  // cannot accept another.
  a_one_beat_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input accepted on two consecutive cycles");

  // A result is only loaded from the emit step, never from idle.
  a_result_not_from_idle: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> !$past(in_ready))
    else $error("result appeared while the controller was idle");
`endif

endmodule
`default_nettype wire
